// ===== hw/rtl/qtdt_pkg.sv =====
// Shared types, command/status structs and modular helpers for the quartic trace test.
// No dependencies.
`default_nettype none
package qtdt_pkg;
    localparam int unsigned RadixBits = 64;  // Montgomery radix 2^64
    localparam int unsigned KWidth    = 60;

    typedef logic [RadixBits-1:0] t_word;

    typedef struct packed {
        logic       load;       // take k, form N and exponent
        logic       one_step;   // one := 2*one mod N
        logic       init_poly;  // acc := 1, pw := x, d := 0
        logic       mm_start;   // load multiplier operands
        logic       mm_src_sq;  // a operand from pw instead of acc
        logic       mm_src_t;   // a operand t, b operand 1
        logic       mm_step;    // one radix-2 Montgomery step
        logic       accum;      // d[i+j] += product
        logic       reduce;     // fold d by x^4 = x + 1
        logic       red_to_pw;  // reduce writes pw instead of acc
        logic       shift_e;
        logic       tr1;
        logic       tr2;
        logic       tr3;
        logic       finish;     // latch result
        logic [1:0] idx_i;
        logic [1:0] idx_j;
    } t_cmd;

    typedef struct packed {
        logic k_over;
        logic e_zero;
        logic e_lsb;
        logic e_hi_zero;
    } t_sts;

    // a + b mod n, for a, b < n
    function automatic t_word mod_add(input t_word a, input t_word b, input t_word n);
        logic [RadixBits:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, n}) s = s - {1'b0, n};
        return s[RadixBits-1:0];
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/qtdt_datapath.sv =====
// Datapath: modulus, exponent, polynomial registers, bit-serial Montgomery unit, result.
// Depends on qtdt_pkg.
`default_nettype none
module qtdt_datapath #(
    parameter int unsigned MOD_WIDTH = 64
) (
    input  wire                           i_clk,
    input  wire  [qtdt_pkg::KWidth-1:0]   i_k,
    input  qtdt_pkg::t_cmd                i_cmd,
    output qtdt_pkg::t_sts                o_sts,
    output logic                          o_is_term,
    output logic [62:0]                   o_residue,
    output logic                          o_range_error
);
    import qtdt_pkg::*;

    localparam t_word KLimit = ((t_word'(1) << (MOD_WIDTH - 1)) - t_word'(4)) / t_word'(12);

    t_word r_n, r_e, r_one, r_t, r_u;
    t_word r_acc [4];
    t_word r_pw  [4];
    t_word r_d   [7];
    t_word r_mm_a, r_mm_b, r_mm_s;
    logic  r_is_term, r_err;
    logic [62:0] r_res;

    logic [RadixBits+1:0] mm_sum;
    t_word mm_res, k_ext, red0, red1, red2, red3;
    logic [2:0] d_idx;

    assign k_ext = t_word'(i_k);
    assign d_idx = {1'b0, i_cmd.idx_i} + {1'b0, i_cmd.idx_j};

    always_comb begin
        mm_sum = {2'b00, r_mm_s} + (r_mm_a[0] ? {2'b00, r_mm_b} : '0);
        if (mm_sum[0]) mm_sum = mm_sum + {2'b00, r_n};
    end
    // final correction: the step loop leaves S < 2N
    assign mm_res = (r_mm_s >= r_n) ? r_mm_s - r_n : r_mm_s;

    assign red0 = mod_add(r_d[0], r_d[4], r_n);
    assign red1 = mod_add(mod_add(r_d[1], r_d[4], r_n), r_d[5], r_n);
    assign red2 = mod_add(mod_add(r_d[2], r_d[5], r_n), r_d[6], r_n);
    assign red3 = mod_add(r_d[3], r_d[6], r_n);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n   <= (k_ext << 3) + (k_ext << 2) + t_word'(3);
            r_e   <= (k_ext << 3) + (k_ext << 2) + t_word'(3);
            r_one <= t_word'(1);
        end
        if (i_cmd.one_step) r_one <= mod_add(r_one, r_one, r_n);
        if (i_cmd.init_poly) begin
            r_acc[0] <= r_one; r_acc[1] <= '0; r_acc[2] <= '0; r_acc[3] <= '0;
            r_pw[0]  <= '0;    r_pw[1]  <= r_one; r_pw[2] <= '0; r_pw[3]  <= '0;
            for (int m = 0; m < 7; m++) r_d[m] <= '0;
        end
        if (i_cmd.mm_start) begin
            r_mm_s <= '0;
            if (i_cmd.mm_src_t) begin
                r_mm_a <= r_t;
                r_mm_b <= t_word'(1);
            end else begin
                r_mm_a <= i_cmd.mm_src_sq ? r_pw[i_cmd.idx_i] : r_acc[i_cmd.idx_i];
                r_mm_b <= r_pw[i_cmd.idx_j];
            end
        end
        if (i_cmd.mm_step) begin
            r_mm_s <= mm_sum[RadixBits:1];
            r_mm_a <= r_mm_a >> 1;
        end
        if (i_cmd.accum) r_d[d_idx] <= mod_add(r_d[d_idx], mm_res, r_n);
        if (i_cmd.reduce) begin
            if (i_cmd.red_to_pw) begin
                r_pw[0] <= red0; r_pw[1] <= red1; r_pw[2] <= red2; r_pw[3] <= red3;
            end else begin
                r_acc[0] <= red0; r_acc[1] <= red1; r_acc[2] <= red2; r_acc[3] <= red3;
            end
            for (int m = 0; m < 7; m++) r_d[m] <= '0;
        end
        if (i_cmd.shift_e) r_e <= r_e >> 1;
        if (i_cmd.tr1) begin
            r_t <= mod_add(r_acc[0], r_acc[0], r_n);
            r_u <= mod_add(r_acc[3], r_acc[3], r_n);
        end
        if (i_cmd.tr2) begin
            r_t <= mod_add(r_t, r_t, r_n);
            r_u <= mod_add(r_u, r_acc[3], r_n);
        end
        if (i_cmd.tr3) r_t <= mod_add(r_t, r_u, r_n);
        if (i_cmd.load && i_cmd.finish) begin
            // out of range: no test
            r_is_term <= 1'b0;
            r_res     <= '0;
            r_err     <= 1'b1;
        end else if (i_cmd.finish) begin
            r_is_term <= (mm_res == '0);
            r_res     <= mm_res[62:0];
            r_err     <= 1'b0;
        end
    end

    assign o_sts.k_over    = (k_ext > KLimit);
    assign o_sts.e_zero    = (r_e == '0);
    assign o_sts.e_lsb     = r_e[0];
    assign o_sts.e_hi_zero = (r_e[RadixBits-1:1] == '0);

    assign o_is_term     = r_is_term;
    assign o_residue     = r_res;
    assign o_range_error = r_err;
endmodule
`default_nettype wire

// ===== hw/rtl/qtdt_ctrl.sv =====
// Controller: sequences constant setup, square-and-multiply, trace and output handshake.
// Depends on qtdt_pkg.
`default_nettype none
module qtdt_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    input  qtdt_pkg::t_sts   i_sts,
    output qtdt_pkg::t_cmd   o_cmd
);
    import qtdt_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0,  S_ONE = 4'd1,  S_INIT = 4'd2, S_CHK = 4'd3,
                           S_MMS  = 4'd4,  S_MMR = 4'd5,  S_ACC  = 4'd6, S_RED = 4'd7,
                           S_SHF  = 4'd8,  S_T1  = 4'd9,  S_T2   = 4'd10, S_T3 = 4'd11,
                           S_FMS  = 4'd12, S_FMR = 4'd13, S_FIN  = 4'd14, S_OUT = 4'd15;

    logic [3:0] r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic [1:0] r_i, n_i, r_j, n_j;
    logic       r_sq, n_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_sq    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_i     <= n_i;
            r_j     <= n_j;
            r_sq    <= n_sq;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_i     = r_i;
        n_j     = r_j;
        n_sq    = r_sq;
        o_cmd   = '0;
        o_cmd.idx_i     = r_i;
        o_cmd.idx_j     = r_j;
        o_cmd.mm_src_sq = r_sq;
        o_cmd.red_to_pw = r_sq;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt = '0;
                    if (i_sts.k_over) begin
                        o_cmd.finish = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_ONE;
                    end
                end
            end
            S_ONE: begin
                o_cmd.one_step = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) n_state = S_INIT;
            end
            S_INIT: begin
                o_cmd.init_poly = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                n_i = '0;
                n_j = '0;
                if (i_sts.e_zero) begin
                    n_state = S_T1;
                end else if (i_sts.e_lsb) begin
                    n_sq = 1'b0;
                    n_state = S_MMS;
                end else begin
                    n_state = S_SHF;
                end
            end
            S_MMS: begin
                o_cmd.mm_start = 1'b1;
                n_cnt = '0;
                n_state = S_MMR;
            end
            S_MMR: begin
                o_cmd.mm_step = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.accum = 1'b1;
                n_j = r_j + 2'd1;
                if (r_j == 2'd3) n_i = r_i + 2'd1;
                n_state = (r_i == 2'd3 && r_j == 2'd3) ? S_RED : S_MMS;
            end
            S_RED: begin
                o_cmd.reduce = 1'b1;
                n_state = r_sq ? S_CHK : S_SHF;
            end
            S_SHF: begin
                o_cmd.shift_e = 1'b1;
                n_i = '0;
                n_j = '0;
                if (i_sts.e_hi_zero) begin
                    n_state = S_CHK;
                end else begin
                    n_sq = 1'b1;
                    n_state = S_MMS;
                end
            end
            S_T1: begin
                o_cmd.tr1 = 1'b1;
                n_state = S_T2;
            end
            S_T2: begin
                o_cmd.tr2 = 1'b1;
                n_state = S_T3;
            end
            S_T3: begin
                o_cmd.tr3 = 1'b1;
                n_state = S_FMS;
            end
            S_FMS: begin
                o_cmd.mm_start = 1'b1;
                o_cmd.mm_src_t = 1'b1;
                n_cnt = '0;
                n_state = S_FMR;
            end
            S_FMR: begin
                o_cmd.mm_step = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
endmodule
`default_nettype wire

// ===== hw/rtl/quartic_trace_divisibility_test_unit.sv =====
// Top level of the quartic trace divisibility test: controller plus datapath.
// Depends on qtdt_pkg, qtdt_ctrl, qtdt_datapath.
//
//  channel | dir | payload
//  --------+-----+---------------------------------------------------------
//  s_axis  | in  | tdata[59:0] index_k
//  m_axis  | out | tdata[0] is_term, [63:1] trace_residue, [64] range_error
//
// One item at a time. Constant setup comes first. Each polynomial product runs
// 16 coefficient products (start, 64 steps and accumulate each) and one fold.
// The exponent is N: one multiply per set bit of N and one square per bit above
// the lowest, with bit control per exponent bit, then the trace and one final
// product, all on the one shared bit-serial Montgomery multiplier. Out-of-range k
// is flagged in the cycle after it is accepted. Reset is synchronous, active low,
// and clears only the controller. A held result blocks new input until taken.
`default_nettype none
module quartic_trace_divisibility_test_unit #(
    parameter int unsigned MOD_WIDTH = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // [59:0] index_k
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [71:0] m_axis_tdata    // [0] is_term, [63:1] trace_residue, [64] range_error
);
    import qtdt_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic        is_term, range_error;
    logic [62:0] residue;

    qtdt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    qtdt_datapath #(.MOD_WIDTH(MOD_WIDTH)) u_dp (
        .i_clk         (i_clk),
        .i_k           (s_axis_tdata[KWidth-1:0]),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_is_term     (is_term),
        .o_residue     (residue),
        .o_range_error (range_error)
    );

    assign m_axis_tdata = {7'd0, range_error, residue, is_term};

    // upper input bits beyond index_k are padding
    logic unused_in;
    assign unused_in = ^s_axis_tdata[63:KWidth];
endmodule
`default_nettype wire
